/* rtl/core/bce_pkg.sv */
package bce_pkg;

    // Counter widths
    localparam int TICK_WIDTH     = 16;
    localparam int DEBOUNCE_WIDTH = 8;

    // Register field widths
    localparam int DBT_W = 8;
    localparam int LPT_W = 16;
    localparam int DCT_W = 16;

    // Compare widths, wide enough for both sides of each compare
    localparam int DCMP_W = (DEBOUNCE_WIDTH > DBT_W) ? DEBOUNCE_WIDTH : DBT_W;
    localparam int LCMP_W = (TICK_WIDTH > LPT_W) ? TICK_WIDTH : LPT_W;
    localparam int WCMP_W = (TICK_WIDTH > DCT_W) ? TICK_WIDTH : DCT_W;

    localparam logic [TICK_WIDTH-1:0]     TICK_MAX = '1;
    localparam logic [DEBOUNCE_WIDTH-1:0] DBC_MAX  = '1;

    localparam logic [1:0] MAX_PRESSES = 2'd2;

    // APB
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PRESS_LEVEL    = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS     = 2'd2;
    localparam logic [1:0] REG_DOUBLE_CLICK   = 2'd3;

    // Reset values
    localparam logic             RST_PRESS_LEVEL  = 1'b0;
    localparam logic [DBT_W-1:0] RST_DEBOUNCE     = 8'd3;
    localparam logic [LPT_W-1:0] RST_LONG_PRESS   = 16'd100;
    localparam logic [DCT_W-1:0] RST_DOUBLE_CLICK = 16'd30;

    // Event and reported state share one code set
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_PRESSED   = 4'b0010,
        PH_REL_WAIT  = 4'b0100,
        PH_LONG_WAIT = 4'b1000
    } t_phase;

endpackage

/* rtl/core/bce_in_if.sv */
interface bce_in_if;
    logic valid;
    logic ready;
    logic sample_level;

    modport source (output valid, output sample_level, input ready);
    modport sink   (input valid, input sample_level, output ready);
endinterface

/* rtl/core/bce_out_if.sv */
interface bce_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [1:0] button_state;

    modport source (output valid, output event_res, output button_state, input ready);
    modport sink   (input valid, input event_res, input button_state, output ready);
endinterface

/* rtl/core/button_click_event_detector.sv */
// Button click event detector.
// i_sample (sink): one transaction per tick carrying the raw button level.
// o_result (source): one transaction per input, carrying event_res
//   (none / click / double / long) and the sticky button_state.
// APB port (psel .. prdata) holds press_level, debounce_ticks,
//   long_press_ticks and double_click_ticks at byte addresses 0, 4, 8, 12.
//   Write only while idle; pready is tied high, reads return the register.
// Latency: the result appears on o_result the cycle after the input is
//   accepted. Throughput: one tick per cycle; the whole update is one pass
//   of compare/increment logic into the state and result registers.
// Stall: the result register holds until taken; while it is full and not
//   being taken, i_sample.ready is low. A result taken in the same cycle
//   frees the slot, so streaming continues with no bubble.
// Reset (synchronous, active low): registers return to their defaults,
//   the debounced level to "released", phase to idle, counters to zero,
//   and the result register empties.
module button_click_event_detector
    import bce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bce_in_if.sink            i_sample,
    bce_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Configuration registers
    logic             r_active;
    logic [DBT_W-1:0] r_dbt;
    logic [LPT_W-1:0] r_lpt;
    logic [DCT_W-1:0] r_dct;

    // Detector state
    logic                      r_stable, n_stable;
    logic [DEBOUNCE_WIDTH-1:0] r_dcnt, n_dcnt;
    t_phase                    r_phase, n_phase;
    logic [TICK_WIDTH-1:0]     r_tick, n_tick;
    logic [1:0]                r_press, n_press;
    t_event                    r_rstate, n_rstate;
    t_event                    n_event;

    // Result register
    logic   r_out_valid;
    t_event r_event;
    t_event r_bstate;

    logic                      acc;
    logic                      cfg_wr;
    logic                      pressed;
    logic [DEBOUNCE_WIDTH-1:0] dcnt_inc;
    logic [TICK_WIDTH-1:0]     tick_inc;

    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign acc            = i_sample.valid && i_sample.ready;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= RST_PRESS_LEVEL;
            r_dbt    <= RST_DEBOUNCE;
            r_lpt    <= RST_LONG_PRESS;
            r_dct    <= RST_DOUBLE_CLICK;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PRESS_LEVEL:    r_active <= pwdata[0];
                REG_DEBOUNCE_TICKS: r_dbt    <= pwdata[DBT_W-1:0];
                REG_LONG_PRESS:     r_lpt    <= pwdata[LPT_W-1:0];
                REG_DOUBLE_CLICK:   r_dct    <= pwdata[DCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PRESS_LEVEL:    prdata = APB_DW'(r_active);
            REG_DEBOUNCE_TICKS: prdata = APB_DW'(r_dbt);
            REG_LONG_PRESS:     prdata = APB_DW'(r_lpt);
            REG_DOUBLE_CLICK:   prdata = APB_DW'(r_dct);
            default:            prdata = '0;
        endcase
    end

    // ---------------- per-tick update ----------------
    // Saturating increments
    assign tick_inc = (r_tick != TICK_MAX) ? r_tick + 1'b1 : r_tick;
    assign dcnt_inc = (r_dcnt != DBC_MAX) ? r_dcnt + 1'b1 : r_dcnt;

    always_comb begin
        n_stable = r_stable;
        n_dcnt   = r_dcnt;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_press  = r_press;
        n_rstate = r_rstate;
        n_event  = EV_NONE;

        // tick counter runs outside idle
        if (r_phase != PH_IDLE) begin
            n_tick = tick_inc;
        end

        // debounce: adopt a differing level once it has persisted long enough
        if (r_stable != i_sample.sample_level) begin
            if (DCMP_W'(dcnt_inc) >= DCMP_W'(r_dbt)) begin
                n_stable = i_sample.sample_level;
                n_dcnt   = '0;
            end else begin
                n_dcnt = dcnt_inc;
            end
        end else begin
            n_dcnt = '0;
        end

        pressed = (n_stable == r_active);

        case (r_phase)
            PH_IDLE: begin
                if (pressed) begin
                    n_phase = PH_PRESSED;
                    n_tick  = '0;
                    n_press = 2'd1;
                end else begin
                    n_rstate = EV_NONE;
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    n_tick  = '0;
                    n_phase = PH_REL_WAIT;
                end else if (LCMP_W'(n_tick) >= LCMP_W'(r_lpt)) begin
                    n_rstate = EV_LONG;
                    n_event  = EV_LONG;
                    n_tick   = '0;
                    n_press  = '0;
                    n_phase  = PH_LONG_WAIT;
                end
            end
            PH_REL_WAIT: begin
                // window closed: report what was collected
                if (WCMP_W'(n_tick) > WCMP_W'(r_dct)) begin
                    if (r_press == 2'd1) begin
                        n_rstate = EV_CLICK;
                        n_event  = EV_CLICK;
                    end else if (r_press == MAX_PRESSES) begin
                        n_rstate = EV_DOUBLE;
                        n_event  = EV_DOUBLE;
                    end
                    n_phase = PH_IDLE;
                    n_press = '0;
                end else if (pressed) begin
                    if (r_press < MAX_PRESSES) begin
                        n_press = r_press + 1'b1;
                    end
                    n_phase = PH_PRESSED;
                    n_tick  = '0;
                end
            end
            PH_LONG_WAIT: begin
                // wait for release after a long press
                if (!pressed) begin
                    n_phase = PH_IDLE;
                    n_press = '0;
                    n_tick  = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= ~RST_PRESS_LEVEL;
            r_dcnt   <= '0;
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_press  <= '0;
            r_rstate <= EV_NONE;
        end else if (acc) begin
            r_stable <= n_stable;
            r_dcnt   <= n_dcnt;
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_press  <= n_press;
            r_rstate <= n_rstate;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_event  <= n_event;
            r_bstate <= n_rstate;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.event_res    = r_event;
    assign o_result.button_state = r_bstate;

    // ---------------- assertions ----------------
    a_long_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_event == EV_LONG) |=> (r_phase == PH_LONG_WAIT))
        else $error("long press did not enter long-wait phase");

    a_event_sets_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event != EV_NONE) |-> (r_bstate == r_event))
        else $error("reported event does not match sticky state");

    a_long_wait_no_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LONG_WAIT) |-> (r_press == 2'd0))
        else $error("press count nonzero in long-wait phase");

    a_press_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press <= MAX_PRESSES)
        else $error("press count above cap");

    a_accept_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted tick produced no result");

endmodule

/* test/button_click_event_detector_test.sv */
module button_click_event_detector_test;
    import bce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Longest receiver hold-off in the stall test, in cycles.
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // Cycles with no transaction on any port before the run is declared hung.
    // The longest legal quiet stretch comes from the hold-off above.
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        t_event ev;
        t_event st;
    } t_report;

    // ------------------------------------------------------------------
    // Clock, reset, ports
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    bce_in_if  sample_if ();
    bce_out_if result_if ();

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    button_click_event_detector dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the detector: register copies and per-tick state
    // ------------------------------------------------------------------
    logic                      cfg_active;
    logic [DBT_W-1:0]          cfg_debounce;
    logic [LPT_W-1:0]          cfg_long;
    logic [DCT_W-1:0]          cfg_double;

    logic                      stable_lvl;
    logic [DEBOUNCE_WIDTH-1:0] deb_cnt;
    t_phase                    ph;
    logic [TICK_WIDTH-1:0]     tick_cnt;
    logic [1:0]                press_cnt;
    t_event                    rep_state;

    t_report expected_reports[$];

    int unsigned errors = 0;
    int unsigned ticks_sent = 0;
    int unsigned reports_checked = 0;
    int unsigned reg_writes = 0;
    bit          allow_idle = 1'b1;
    bit          hold_req = 1'b0;
    bit          run_started = 1'b0;

    function automatic void reset_shadow();
        cfg_active   = RST_PRESS_LEVEL;
        cfg_debounce = RST_DEBOUNCE;
        cfg_long     = RST_LONG_PRESS;
        cfg_double   = RST_DOUBLE_CLICK;
        stable_lvl   = ~RST_PRESS_LEVEL;
        deb_cnt      = '0;
        ph           = PH_IDLE;
        tick_cnt     = '0;
        press_cnt    = '0;
        rep_state    = EV_NONE;
    endfunction

    // One tick of the detector: debounce, then the phase machine.
    function automatic t_report detect_tick(input logic lvl);
        t_report r;
        logic    pressed;
        r.ev = EV_NONE;

        // tick counter saturates, never wraps
        if (ph != PH_IDLE && tick_cnt != TICK_MAX)
            tick_cnt++;

        if (stable_lvl != lvl) begin
            if (deb_cnt != DBC_MAX)
                deb_cnt++;
            if (deb_cnt >= cfg_debounce) begin
                stable_lvl = lvl;
                deb_cnt = '0;
            end
        end else begin
            deb_cnt = '0;
        end

        pressed = (stable_lvl == cfg_active);

        case (ph)
            PH_IDLE: begin
                if (pressed) begin
                    ph = PH_PRESSED;
                    tick_cnt = '0;
                    press_cnt = 2'd1;
                end else begin
                    rep_state = EV_NONE;
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    tick_cnt = '0;
                    ph = PH_REL_WAIT;
                end else if (tick_cnt >= cfg_long) begin
                    rep_state = EV_LONG;
                    r.ev = EV_LONG;
                    tick_cnt = '0;
                    press_cnt = '0;
                    ph = PH_LONG_WAIT;
                end
            end
            PH_REL_WAIT: begin
                if (tick_cnt > cfg_double) begin
                    if (press_cnt == 2'd1) begin
                        rep_state = EV_CLICK;
                        r.ev = EV_CLICK;
                    end else if (press_cnt == 2'd2) begin
                        rep_state = EV_DOUBLE;
                        r.ev = EV_DOUBLE;
                    end
                    ph = PH_IDLE;
                    press_cnt = '0;
                end else if (pressed) begin
                    if (press_cnt < MAX_PRESSES)
                        press_cnt++;
                    ph = PH_PRESSED;
                    tick_cnt = '0;
                end
            end
            default: begin
                if (!pressed) begin
                    ph = PH_IDLE;
                    press_cnt = '0;
                    tick_cnt = '0;
                end
            end
        endcase

        r.st = rep_state;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one tick per transaction, random gaps when allowed.
    // valid stays high across back-to-back transactions; it only drops
    // in a gap or when a test drains.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic lvl);
        int unsigned gap;
        if (allow_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.sample_level <= lvl;
        do @(posedge i_clk); while (!sample_if.ready);
        // accepted at this edge: predict its report
        expected_reports.push_back(detect_tick(lvl));
        ticks_sent++;
    endtask

    task automatic send_run(input logic lvl, input int unsigned n);
        repeat (n) send_tick(lvl);
    endtask

    // A run of one level whose first two ticks may bounce.
    task automatic send_bouncy(input logic lvl, input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (i < 2 && $urandom_range(0, 3) == 0)
                send_tick(!lvl);
            else
                send_tick(lvl);
        end
    endtask

    // Stop offering, wait for every report, then let the result
    // register settle so a register write finds the block idle.
    task automatic drain_reports();
        sample_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // APB access: setup phase, access phase, then an idle phase after
    // ------------------------------------------------------------------
    task automatic set_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_PRESS_LEVEL:    cfg_active   = value[0];
            REG_DEBOUNCE_TICKS: cfg_debounce = value[DBT_W-1:0];
            REG_LONG_PRESS:     cfg_long     = value[LPT_W-1:0];
            REG_DOUBLE_CLICK:   cfg_double   = value[DCT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== want) begin
            errors++;
            $display("%0t: register %0d read expected %h actual %h", $time, idx, want, got);
        end
    endtask

    task automatic set_all(input logic act, input logic [DBT_W-1:0] dbt,
                           input logic [LPT_W-1:0] lpt, input logic [DCT_W-1:0] dct);
        set_reg(REG_PRESS_LEVEL, APB_DW'(act));
        set_reg(REG_DEBOUNCE_TICKS, APB_DW'(dbt));
        set_reg(REG_LONG_PRESS, APB_DW'(lpt));
        set_reg(REG_DOUBLE_CLICK, APB_DW'(dct));
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each report against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_report exp_r;
        if (run_started && result_if.valid && result_if.ready) begin
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected report expected none actual ev=%0d st=%0d",
                         $time, result_if.event_res, result_if.button_state);
            end else begin
                exp_r = expected_reports.pop_front();
                reports_checked++;
                if (result_if.event_res !== exp_r.ev) begin
                    errors++;
                    $display("%0t: event_res expected %0d actual %0d",
                             $time, exp_r.ev, result_if.event_res);
                end
                if (result_if.button_state !== exp_r.st) begin
                    errors++;
                    $display("%0t: button_state expected %0d actual %0d",
                             $time, exp_r.st, result_if.button_state);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random short stalls, or one long hold-off on request
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
        end else if (stall_left == 0 && allow_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 6);
        end
        if (stall_left != 0) begin
            stall_left--;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transaction on any port resets the quiet count
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((sample_if.valid === 1'b1 && sample_if.ready === 1'b1) ||
            (result_if.valid === 1'b1 && result_if.ready === 1'b1) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values read back, then a click at the reset settings
    // (debounce 3, window 30). The pin starts released (level 1).
    task automatic test_reset_defaults();
        check_reg(REG_PRESS_LEVEL, APB_DW'(RST_PRESS_LEVEL));
        check_reg(REG_DEBOUNCE_TICKS, APB_DW'(RST_DEBOUNCE));
        check_reg(REG_LONG_PRESS, APB_DW'(RST_LONG_PRESS));
        check_reg(REG_DOUBLE_CLICK, APB_DW'(RST_DOUBLE_CLICK));
        send_run(1'b1, 3);
        send_run(1'b0, 8);
        send_run(1'b1, 40);
        drain_reports();
    endtask

    // Every register at all-ones and all-zeros, read back each time.
    task automatic test_register_access();
        set_all(1'b1, '1, '1, '1);
        check_reg(REG_PRESS_LEVEL, APB_DW'(1'b1));
        check_reg(REG_DEBOUNCE_TICKS, APB_DW'(DBT_W'('1)));
        check_reg(REG_LONG_PRESS, APB_DW'(LPT_W'('1)));
        check_reg(REG_DOUBLE_CLICK, APB_DW'(DCT_W'('1)));
        set_all(1'b0, '0, '0, '0);
        check_reg(REG_PRESS_LEVEL, '0);
        check_reg(REG_DEBOUNCE_TICKS, '0);
        check_reg(REG_LONG_PRESS, '0);
        check_reg(REG_DOUBLE_CLICK, '0);
    endtask

    // Zero debounce, zero long press, zero window: long press on the
    // second held tick, click as soon as the release is one tick old.
    task automatic test_zero_settings();
        set_all(1'b0, 8'd0, 16'd0, 16'd0);
        send_run(1'b0, 3);
        send_run(1'b1, 3);
        drain_reports();
        set_reg(REG_LONG_PRESS, 32'd4);
        send_run(1'b0, 1);
        send_run(1'b1, 3);
        send_run(1'b0, 2);
        send_run(1'b1, 1);
        send_run(1'b0, 2);
        send_run(1'b1, 3);
        drain_reports();
    endtask

    // Click, double click, three presses (counted as two), long press,
    // and a glitch shorter than the debounce time.
    task automatic test_gestures();
        set_all(1'b0, 8'd1, 16'd6, 16'd4);
        send_run(1'b0, 3);  send_run(1'b1, 8);
        send_run(1'b0, 2);  send_run(1'b1, 2);  send_run(1'b0, 2);  send_run(1'b1, 8);
        repeat (3) begin
            send_run(1'b0, 2);  send_run(1'b1, 2);
        end
        send_run(1'b1, 6);
        send_run(1'b0, 12); send_run(1'b1, 4);
        drain_reports();
        set_reg(REG_DEBOUNCE_TICKS, 32'd3);
        send_run(1'b0, 1);  send_run(1'b1, 3);  send_run(1'b0, 2);  send_run(1'b1, 10);
        drain_reports();
    endtask

    // Largest debounce: the press is adopted on its 255th tick, which
    // fixes when the long press that follows is reported.
    task automatic test_max_debounce();
        set_all(1'b0, 8'd255, 16'd8, 16'd5);
        send_run(1'b0, 266);
        drain_reports();
        set_reg(REG_DEBOUNCE_TICKS, 32'd2);
        send_run(1'b1, 4);
        drain_reports();
    endtask

    // Rewriting the press level leaves the debounced level alone, so the
    // meaning of the held level flips on the next tick.
    task automatic test_active_flip();
        set_all(1'b0, 8'd2, 16'd20, 16'd4);
        send_run(1'b1, 6);
        drain_reports();
        // released level now reads as pressed
        set_reg(REG_PRESS_LEVEL, 32'd1);
        send_run(1'b1, 5);
        drain_reports();
        // held level now reads as released: click after the window
        set_reg(REG_PRESS_LEVEL, 32'd0);
        send_run(1'b1, 8);
        send_run(1'b0, 3);
        drain_reports();
        set_reg(REG_PRESS_LEVEL, 32'd1);
        send_run(1'b0, 4);
        send_run(1'b1, 30);
        send_run(1'b0, 6);
        drain_reports();
    endtask

    // Receiver holds off for a long stretch while the sender keeps
    // offering: the single result slot fills and input ready drops.
    task automatic test_backpressure();
        set_all(1'b0, 8'd1, 16'd8, 16'd3);
        allow_idle = 1'b0;
        hold_req = 1'b1;
        send_run(1'b0, 4);
        send_run(1'b1, 6);
        send_run(1'b0, 2);
        send_run(1'b1, 20);
        drain_reports();
        allow_idle = 1'b1;
    endtask

    // One random gesture: pin noise, or a bouncy press and release with
    // lengths spread around the thresholds.
    task automatic random_gesture();
        int unsigned plen;
        int unsigned rlen;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
        end else begin
            plen = $urandom_range(1, cfg_long + cfg_debounce + 4);
            rlen = $urandom_range(1, cfg_double + cfg_debounce + 6);
            send_bouncy(cfg_active, plen);
            send_bouncy(!cfg_active, rlen);
        end
    endtask

    // Random gestures over several settings; the last round runs with
    // no idling on either side.
    task automatic test_random();
        int unsigned start;
        for (int r = 0; r < 5; r++) begin
            case (r)
                0: set_all(1'b0, 8'($urandom_range(1, 4)), 16'($urandom_range(2, 20)),
                           16'($urandom_range(0, 12)));
                1: set_all(1'b1, 8'd0, 16'd1, 16'd0);
                2: set_all(1'b1, 8'($urandom_range(0, 3)), 16'($urandom_range(1, 40)),
                           16'($urandom_range(0, 30)));
                3: set_all(1'b0, 8'($urandom_range(2, 6)), 16'($urandom_range(10, 60)),
                           16'($urandom_range(5, 40)));
                default: begin
                    allow_idle = 1'b0;
                    set_all(1'($urandom_range(0, 1)), 8'($urandom_range(0, 4)),
                            16'($urandom_range(1, 25)), 16'($urandom_range(0, 15)));
                end
            endcase
            start = ticks_sent;
            while (ticks_sent - start < 50) random_gesture();
            drain_reports();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        sample_if.valid = 1'b0;
        sample_if.sample_level = 1'b1;
        result_if.ready = 1'b0;
        reset_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_started = 1'b1;

        test_reset_defaults();
        test_register_access();
        test_zero_settings();
        test_gestures();
        test_max_debounce();
        test_active_flip();
        test_backpressure();
        test_random();

        drain_reports();
        repeat (4) @(posedge i_clk);

        $display("covered %0d ticks, %0d reports checked, %0d register writes",
                 ticks_sent, reports_checked, reg_writes);
        $display("gestures, zero and largest debounce, level flips and a long stall");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
